// File: hw/rtl/rwit_pkg.sv
// shared constants, codes and control/status types for the interval timer
package rwit_pkg;

  localparam int WINDOW_MAX = 16;
  localparam int DUR_W      = 48;
  localparam int COUNT_W    = 5;
  localparam int CMD_W      = 3;
  localparam int SEL_W      = 2;

  localparam int RING_AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_W   = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W   = DUR_W + CNT_W;
  localparam int DIVC_W  = $clog2(SUM_W + 1);

  localparam logic [COUNT_W-1:0] WSIZE_RESET = COUNT_W'(WINDOW_MAX);

  // command codes
  localparam logic [CMD_W-1:0] CMD_BEGIN  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_END    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PAUSE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RESUME = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TICK   = 3'd4;

  // statistic select codes
  localparam logic [SEL_W-1:0] SEL_AVG    = 2'd0;
  localparam logic [SEL_W-1:0] SEL_LATEST = 2'd1;
  localparam logic [SEL_W-1:0] SEL_MIN    = 2'd2;
  localparam logic [SEL_W-1:0] SEL_MAX    = 2'd3;

  // commands from controller to datapath
  typedef struct packed {
    logic take;
    logic walk_step;
    logic div_load;
    logic div_step;
    logic emit;
  } rwit_ctl_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_end;
    logic walk_done;
    logic div_done;
    logic out_free;
  } rwit_stat_t;

endpackage

// File: hw/rtl/rolling_window_interval_timer.sv
// top level of the rolling window interval timer
// A pausable interval timer: each tick request adds one unit to the running
// segment, begin/pause/resume steer it, and an end request stores the measured
// duration in a ring of window_size entries, clamped to 1..WINDOW_MAX. Every
// request yields one result with the latest, minimum, maximum and truncated
// average duration over the filled entries plus the statistic picked by
// stat_select. For begin, pause, resume, tick and unknown commands the request
// is accepted and, if the result register is free, its result is registered
// at the same edge; a new request is taken the following cycle even while
// that result is still stalled (one further request is then held until the
// result register frees). An end request walks the ring one entry a cycle
// through its single registered read port to gather min, max and sum, and the
// average comes from a one-bit-per-cycle restoring divider over the 53-bit
// sum. Writing window_size clears the ring position, count and statistics at
// once, with no clearing pass; it must only be written while the block is idle.
module rolling_window_interval_timer
  import rwit_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_wr_en,
  input  logic [COUNT_W-1:0] cfg_wr_data,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CMD_W-1:0]   cmd,
  input  logic [SEL_W-1:0]   stat_select,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [DUR_W-1:0]   latest_duration,
  output logic [DUR_W-1:0]   min_duration,
  output logic [DUR_W-1:0]   max_duration,
  output logic [DUR_W-1:0]   average_duration,
  output logic [DUR_W-1:0]   selected_duration,
  output logic [COUNT_W-1:0] filled_count
);

  rwit_ctl_t  ctl;
  rwit_stat_t stat;

  // sequencing: intake, walk, divide, result hand-off
  rwit_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctl      (ctl)
  );

  // counters, ring, statistics and result register
  rwit_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .cmd               (cmd),
    .stat_select       (stat_select),
    .out_stall         (out_stall),
    .ctl               (ctl),
    .stat              (stat),
    .out_valid         (out_valid),
    .latest_duration   (latest_duration),
    .min_duration      (min_duration),
    .max_duration      (max_duration),
    .average_duration  (average_duration),
    .selected_duration (selected_duration),
    .filled_count      (filled_count)
  );

  // an accepted end request starts the walk, so intake closes next cycle
  a_end_blocks_intake : assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (cmd == CMD_END)) |=> in_stall)
    else $error("end request did not start the statistics walk");

  // an empty window reports the empty statistics
  a_empty_stats : assert property (@(posedge clk) disable iff (rst)
    (out_valid && (filled_count == '0)) |->
      ((min_duration == '1) && (max_duration == '0) && (average_duration == '0)))
    else $error("empty window reported non-empty statistics");

  // a filled window keeps min <= average <= max
  a_stats_order : assert property (@(posedge clk) disable iff (rst)
    (out_valid && (filled_count != '0)) |->
      ((min_duration <= average_duration) && (average_duration <= max_duration)))
    else $error("window statistics out of order");

endmodule

// File: hw/rtl/rwit_ctrl.sv
// controller state machine: request intake, ring walk, divide and result hand-off
module rwit_ctrl
  import rwit_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  rwit_stat_t stat,
  output rwit_ctl_t  ctl
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DIV,
    S_HOLD
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.take = 1'b1;
          if (stat.is_end) begin
            state_next = S_WALK;
          end else if (stat.out_free) begin
            ctl.emit = 1'b1;
          end else begin
            state_next = S_HOLD;
          end
        end
      end
      S_WALK: begin
        if (stat.walk_done) begin
          ctl.div_load = 1'b1;
          state_next   = S_DIV;
        end else begin
          ctl.walk_step = 1'b1;
        end
      end
      S_DIV: begin
        if (!stat.div_done) begin
          ctl.div_step = 1'b1;
        end else if (stat.out_free) begin
          ctl.emit   = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_HOLD;
        end
      end
      S_HOLD: begin
        if (stat.out_free) begin
          ctl.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

endmodule

// File: hw/rtl/rwit_dp.sv
// datapath: tick counters, duration ring, statistics walk, serial divider, result register
module rwit_dp
  import rwit_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [COUNT_W-1:0] cfg_wr_data,
  input  logic [CMD_W-1:0]   cmd,
  input  logic [SEL_W-1:0]   stat_select,
  input  logic               out_stall,
  input  rwit_ctl_t          ctl,
  output rwit_stat_t         stat,
  output logic               out_valid,
  output logic [DUR_W-1:0]   latest_duration,
  output logic [DUR_W-1:0]   min_duration,
  output logic [DUR_W-1:0]   max_duration,
  output logic [DUR_W-1:0]   average_duration,
  output logic [DUR_W-1:0]   selected_duration,
  output logic [COUNT_W-1:0] filled_count
);

  localparam logic [DUR_W-1:0] DUR_ONES = '1;

  // timer and window state
  logic [COUNT_W-1:0] wsize;
  logic [DUR_W-1:0]   seg_ticks;
  logic [DUR_W-1:0]   carried_ticks;
  logic               paused;
  logic [RING_AW-1:0] wp;
  logic [CNT_W-1:0]   count;
  logic [DUR_W-1:0]   latest;
  logic [SEL_W-1:0]   sel_q;

  // ring memory and walk
  logic [DUR_W-1:0]   ring [WINDOW_MAX];
  logic [DUR_W-1:0]   rd_data;
  logic               rd_vld;
  logic [CNT_W-1:0]   idx;
  logic [DUR_W-1:0]   mn;
  logic [DUR_W-1:0]   mx;
  logic [SUM_W-1:0]   sum;

  // divider
  logic [SUM_W-1:0]   dq;
  logic [CNT_W-1:0]   div_rem;
  logic [DIVC_W-1:0]  div_cnt;
  logic [CNT_W:0]     div_t;
  logic               div_ge;

  // combinational helpers
  logic [CNT_W-1:0]   size_eff;
  logic [RING_AW-1:0] wp_use;
  logic [CNT_W-1:0]   wp_inc;
  logic [DUR_W:0]     end_sum;
  logic [DUR_W-1:0]   end_val;
  logic [DUR_W:0]     pause_sum;
  logic [DUR_W-1:0]   pause_val;
  logic [DUR_W:0]     tick_sum;
  logic [DUR_W-1:0]   tick_val;
  logic [SEL_W-1:0]   sel_use;
  logic [DUR_W-1:0]   sel_val;

  always_comb begin
    if (wsize == '0) begin
      size_eff = CNT_W'(1);
    end else if (32'(wsize) > WINDOW_MAX) begin
      size_eff = CNT_W'(WINDOW_MAX);
    end else begin
      size_eff = CNT_W'(wsize);
    end
  end

  assign wp_use = (CNT_W'(wp) >= size_eff) ? '0 : wp;
  assign wp_inc = CNT_W'(wp_use) + CNT_W'(1);

  // saturating adds
  assign end_sum   = {1'b0, (paused ? '0 : seg_ticks)} + {1'b0, carried_ticks};
  assign end_val   = end_sum[DUR_W] ? DUR_ONES : end_sum[DUR_W-1:0];
  assign pause_sum = {1'b0, carried_ticks} + {1'b0, seg_ticks};
  assign pause_val = pause_sum[DUR_W] ? DUR_ONES : pause_sum[DUR_W-1:0];
  assign tick_sum  = {1'b0, seg_ticks} + (DUR_W + 1)'(1);
  assign tick_val  = tick_sum[DUR_W] ? DUR_ONES : tick_sum[DUR_W-1:0];

  assign div_t  = {div_rem, dq[SUM_W-1]};
  assign div_ge = (div_t >= {1'b0, count});

  always_ff @(posedge clk) begin
    if (rst) begin
      wsize         <= WSIZE_RESET;
      seg_ticks     <= '0;
      carried_ticks <= '0;
      paused        <= 1'b0;
      wp            <= '0;
      count         <= '0;
      latest        <= '0;
      mn            <= DUR_ONES;
      mx            <= '0;
      dq            <= '0;
      rd_vld        <= 1'b0;
    end else if (cfg_wr_en) begin
      wsize  <= cfg_wr_data;
      wp     <= '0;
      count  <= '0;
      latest <= '0;
      mn     <= DUR_ONES;
      mx     <= '0;
      dq     <= '0;
    end else begin
      if (ctl.take) begin
        unique case (cmd)
          CMD_BEGIN: begin
            carried_ticks <= '0;
            seg_ticks     <= '0;
            paused        <= 1'b0;
          end
          CMD_END: begin
            latest <= end_val;
            wp     <= (wp_inc == size_eff) ? '0 : RING_AW'(wp_inc);
            if (count < size_eff) begin
              count <= count + CNT_W'(1);
            end
            paused <= 1'b0;
            // restart the statistics walk
            idx    <= '0;
            rd_vld <= 1'b0;
            mn     <= DUR_ONES;
            mx     <= '0;
            sum    <= '0;
          end
          CMD_PAUSE: begin
            if (!paused) begin
              carried_ticks <= pause_val;
              paused        <= 1'b1;
            end
          end
          CMD_RESUME: begin
            if (paused) begin
              seg_ticks <= '0;
              paused    <= 1'b0;
            end
          end
          CMD_TICK: begin
            seg_ticks <= tick_val;
          end
          default: begin
          end
        endcase
      end
      if (ctl.walk_step) begin
        if (idx < count) begin
          idx    <= idx + CNT_W'(1);
          rd_vld <= 1'b1;
        end else begin
          rd_vld <= 1'b0;
        end
        if (rd_vld) begin
          sum <= sum + SUM_W'(rd_data);
          if (rd_data < mn) begin
            mn <= rd_data;
          end
          if (rd_data > mx) begin
            mx <= rd_data;
          end
        end
      end
      if (ctl.div_load) begin
        dq      <= sum;
        div_rem <= '0;
        div_cnt <= '0;
      end else if (ctl.div_step) begin
        dq      <= {dq[SUM_W-2:0], div_ge};
        div_rem <= div_ge ? CNT_W'(div_t - {1'b0, count}) : div_t[CNT_W-1:0];
        div_cnt <= div_cnt + DIVC_W'(1);
      end
    end
  end

  // ring storage, registered read
  always_ff @(posedge clk) begin
    if (ctl.take && !cfg_wr_en && (cmd == CMD_END)) begin
      ring[wp_use] <= end_val;
    end
    rd_data <= ring[idx[RING_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      sel_q <= stat_select;
    end
  end

  assign sel_use = ctl.take ? stat_select : sel_q;

  always_comb begin
    unique case (sel_use)
      SEL_AVG:    sel_val = dq[DUR_W-1:0];
      SEL_LATEST: sel_val = latest;
      SEL_MIN:    sel_val = mn;
      SEL_MAX:    sel_val = mx;
      default:    sel_val = mx;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      latest_duration   <= latest;
      min_duration      <= mn;
      max_duration      <= mx;
      average_duration  <= dq[DUR_W-1:0];
      selected_duration <= sel_val;
      filled_count      <= COUNT_W'(count);
    end
  end

  assign stat.is_end    = (cmd == CMD_END);
  assign stat.walk_done = (idx == count) && !rd_vld;
  assign stat.div_done  = (div_cnt == DIVC_W'(SUM_W));
  assign stat.out_free  = !out_valid || !out_stall;

endmodule

// File: tb/rolling_window_interval_timer_tb.sv
// self-checking testbench for the rolling window interval timer
module rolling_window_interval_timer_tb;
  import rwit_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // commands the block does not know, still answered with a result
  localparam logic [CMD_W-1:0] CMD_SPARE_5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  // window size codes used by the phases
  localparam logic [COUNT_W-1:0] WSIZE_ZERO = 5'd0;
  localparam logic [COUNT_W-1:0] WSIZE_ONE  = 5'd1;
  localparam logic [COUNT_W-1:0] WSIZE_TOP  = 5'd31;

  // slowest run: ~700 requests, each after a random gap, the window walk and
  // division for an end, and receiver stall stretches
  localparam int CYCLE_LIMIT = 600_000;

  // one result as seen on the output ports
  typedef struct packed {
    logic [DUR_W-1:0]   latest;
    logic [DUR_W-1:0]   shortest;
    logic [DUR_W-1:0]   longest;
    logic [DUR_W-1:0]   mean;
    logic [DUR_W-1:0]   chosen;
    logic [COUNT_W-1:0] filled;
  } timer_stats_t;

  // timer model plus the queue of statistics still owed by the block
  class interval_scoreboard;
    logic [COUNT_W-1:0] wsize;
    logic [DUR_W-1:0]   ring [WINDOW_MAX];
    int unsigned        wpos;
    int unsigned        count;
    logic [DUR_W-1:0]   seg_ticks;
    logic [DUR_W-1:0]   carried;
    logic               paused;
    timer_stats_t       expected_stats [$];
    int                 fail_count;

    function new();
      wsize      = WSIZE_RESET;
      seg_ticks  = '0;
      carried    = '0;
      paused     = 1'b0;
      fail_count = 0;
      clear_ring();
    endfunction

    function void clear_ring();
      foreach (ring[i]) ring[i] = '0;
      wpos  = 0;
      count = 0;
    endfunction

    function void write_window(logic [COUNT_W-1:0] value);
      wsize = value;
      clear_ring();
    endfunction

    function int unsigned window_len();
      if (wsize == 0) return 1;
      if (wsize > WINDOW_MAX) return WINDOW_MAX;
      return 32'(wsize);
    endfunction

    function logic [DUR_W-1:0] sat_add(logic [DUR_W-1:0] a, logic [DUR_W-1:0] b);
      logic [DUR_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[DUR_W] ? {DUR_W{1'b1}} : s[DUR_W-1:0];
    endfunction

    function int pending();
      return expected_stats.size();
    endfunction

    task report_mismatch(string msg);
      if (fail_count < 40) $display("mismatch: %s", msg);
      fail_count++;
    endtask

    // advance the timer by one accepted request and queue its statistics
    function void note_request(logic [CMD_W-1:0] c, logic [SEL_W-1:0] s);
      timer_stats_t      r;
      int unsigned       size;
      int unsigned       n;
      logic [DUR_W+7:0]  total;
      size = window_len();
      case (c)
        CMD_BEGIN: begin
          carried   = '0;
          seg_ticks = '0;
          paused    = 1'b0;
        end
        CMD_END: begin
          if (wpos >= size) wpos = 0;
          // paused end keeps only what was carried; ticks are not cleared
          ring[wpos] = sat_add(paused ? '0 : seg_ticks, carried);
          wpos = (wpos + 1) % size;
          if (count < size) count++;
          paused = 1'b0;
        end
        CMD_PAUSE: begin
          if (!paused) begin
            carried = sat_add(carried, seg_ticks);
            paused  = 1'b1;
          end
        end
        CMD_RESUME: begin
          if (paused) begin
            seg_ticks = '0;
            paused    = 1'b0;
          end
        end
        CMD_TICK: seg_ticks = sat_add(seg_ticks, DUR_W'(1));
        default: ;
      endcase
      n          = (count < size) ? count : size;
      r.latest   = ring[(wpos + size - 1) % size];
      r.shortest = {DUR_W{1'b1}};
      r.longest  = '0;
      total      = '0;
      for (int i = 0; i < n; i++) begin
        if (ring[i] < r.shortest) r.shortest = ring[i];
        if (ring[i] > r.longest) r.longest = ring[i];
        total += ring[i];
      end
      r.mean = (n == 0) ? '0 : DUR_W'(total / n);
      case (s)
        SEL_AVG:    r.chosen = r.mean;
        SEL_LATEST: r.chosen = r.latest;
        SEL_MIN:    r.chosen = r.shortest;
        default:    r.chosen = r.longest;
      endcase
      r.filled = COUNT_W'(n);
      expected_stats.push_back(r);
    endfunction

    task compare_field(string name, logic [DUR_W-1:0] got, logic [DUR_W-1:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task check_result(timer_stats_t got);
      timer_stats_t want;
      if (expected_stats.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = expected_stats.pop_front();
        compare_field("latest_duration", got.latest, want.latest);
        compare_field("min_duration", got.shortest, want.shortest);
        compare_field("max_duration", got.longest, want.longest);
        compare_field("average_duration", got.mean, want.mean);
        compare_field("selected_duration", got.chosen, want.chosen);
        compare_field("filled_count", DUR_W'(got.filled), DUR_W'(want.filled));
      end
    endtask
  endclass

  // every input of the block starts from a known value
  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               cfg_wr_en   = 1'b0;
  logic [COUNT_W-1:0] cfg_wr_data = '0;
  logic               in_valid    = 1'b0;
  logic               in_stall;
  logic [CMD_W-1:0]   cmd         = CMD_BEGIN;
  logic [SEL_W-1:0]   stat_select = SEL_AVG;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  logic [DUR_W-1:0]   latest_duration;
  logic [DUR_W-1:0]   min_duration;
  logic [DUR_W-1:0]   max_duration;
  logic [DUR_W-1:0]   average_duration;
  logic [DUR_W-1:0]   selected_duration;
  logic [COUNT_W-1:0] filled_count;

  interval_scoreboard sb = new();

  int cycle_count = 0;
  int burst_left  = 0;
  int stall_left  = 0;
  int stall_mode  = 0;

  always #1 clk = ~clk;

  rolling_window_interval_timer i_dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .cmd               (cmd),
    .stat_select       (stat_select),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .latest_duration   (latest_duration),
    .min_duration      (min_duration),
    .max_duration      (max_duration),
    .average_duration  (average_duration),
    .selected_duration (selected_duration),
    .filled_count      (filled_count)
  );

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver back-pressure: stretches of no stall, light, even and heavy stall
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(5, 40);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // result monitor: values read here are the ones before the edge
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result('{latest_duration, min_duration, max_duration,
                        average_duration, selected_duration, filled_count});
  end

  // drive one request and hold it until the block takes it; the sender
  // runs in bursts, and a zero gap keeps valid high across requests
  task automatic send_request(logic [CMD_W-1:0] c, logic [SEL_W-1:0] s);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid    <= 1'b1;
    cmd         <= c;
    stat_select <= s;
    do @(posedge clk); while (in_stall);
    sb.note_request(c, s);
  endtask

  // window size may only change with the block idle and nothing owed
  task automatic set_window_size(logic [COUNT_W-1:0] value);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    cfg_wr_data <= value;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.write_window(value);
  endtask

  // mostly well-formed begin/tick/pause/resume/end runs with random content;
  // now and then the begin is dropped, ends repeat or junk requests slip in
  task automatic run_measurement();
    if ($urandom_range(0, 7) != 0) send_request(CMD_BEGIN, SEL_W'($urandom_range(0, 3)));
    repeat ($urandom_range(0, 6)) send_request(CMD_TICK, SEL_W'($urandom_range(0, 3)));
    if ($urandom_range(0, 2) == 0) begin
      send_request(CMD_PAUSE, SEL_W'($urandom_range(0, 3)));
      if ($urandom_range(0, 3) == 0) send_request(CMD_PAUSE, SEL_W'($urandom_range(0, 3)));
      // ticks while paused still count but are thrown away by resume
      repeat ($urandom_range(0, 4)) send_request(CMD_TICK, SEL_W'($urandom_range(0, 3)));
      if ($urandom_range(0, 4) != 0) begin
        send_request(CMD_RESUME, SEL_W'($urandom_range(0, 3)));
        repeat ($urandom_range(0, 5)) send_request(CMD_TICK, SEL_W'($urandom_range(0, 3)));
      end
    end
    send_request(CMD_END, SEL_W'($urandom_range(0, 3)));
    if ($urandom_range(0, 7) == 0) send_request(CMD_END, SEL_W'($urandom_range(0, 3)));
    if ($urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 3))
        send_request(CMD_W'($urandom_range(0, 7)), SEL_W'($urandom_range(0, 3)));
  endtask

  initial begin
    logic [COUNT_W-1:0] sizes [8];
    sizes = '{WSIZE_ONE, WSIZE_ZERO, WSIZE_TOP, 5'd3, WSIZE_RESET, 5'd17,
              5'd7, COUNT_W'($urandom_range(1, 31))};

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: empty window statistics at the reset window size
    send_request(CMD_BEGIN, SEL_MIN);
    send_request(CMD_BEGIN, SEL_MAX);
    // zero length measurement
    send_request(CMD_END, SEL_LATEST);
    send_request(CMD_TICK, SEL_AVG);
    send_request(CMD_TICK, SEL_MIN);
    send_request(CMD_TICK, SEL_MAX);
    send_request(CMD_END, SEL_AVG);
    // end while paused stores only the carried ticks
    send_request(CMD_PAUSE, SEL_LATEST);
    send_request(CMD_TICK, SEL_LATEST);
    send_request(CMD_TICK, SEL_MAX);
    send_request(CMD_END, SEL_LATEST);
    // resume when not paused and a second pause both do nothing
    send_request(CMD_RESUME, SEL_MIN);
    send_request(CMD_PAUSE, SEL_AVG);
    send_request(CMD_PAUSE, SEL_AVG);
    send_request(CMD_RESUME, SEL_MAX);
    send_request(CMD_TICK, SEL_AVG);
    // ends without a begin measure again from the same start
    send_request(CMD_END, SEL_LATEST);
    send_request(CMD_END, SEL_AVG);
    // unknown commands leave everything alone
    send_request(CMD_SPARE_5, SEL_MIN);
    send_request(CMD_SPARE_6, SEL_MAX);
    send_request(CMD_SPARE_7, SEL_LATEST);
    send_request(CMD_BEGIN, SEL_AVG);
    send_request(CMD_TICK, SEL_MAX);
    send_request(CMD_END, SEL_MIN);

    // random phases over the window sizes, zero and out of range among them;
    // big windows get enough ends to wrap the ring
    foreach (sizes[p]) begin
      set_window_size(sizes[p]);
      repeat ((sb.window_len() > 8) ? 16 : 8) run_measurement();
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    // stray results would show within an end's walk and division time
    repeat (100) @(posedge clk);

    if (sb.fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
